// ===== rtl/core/pid_dm_pkg.sv =====
// Shared types and fixed constants of the dual-mode PID controller.
package pid_dm_pkg;

    // Fixed field widths
    localparam int DATA_W  = 24;
    localparam int GAIN_W  = 20;
    localparam int DRIVE_W = 11;

    // Drive saturation, integral limit and small-setpoint threshold in whole units
    localparam int DRIVE_LIMIT   = 1000;
    localparam int INC_INT_UNITS = 300;
    localparam int SMALL_SP      = 30;

    // Register map
    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_GAIN_P = 2'd1,
        CFG_GAIN_I = 2'd2,
        CFG_GAIN_D = 2'd3
    } t_cfg_idx;

    // Control law
    typedef enum logic {
        MODE_POS = 1'b0,
        MODE_INC = 1'b1
    } t_mode;

endpackage

// ===== rtl/core/pid_controller_dual_mode_top.sv =====
// Dual-mode (positional / incremental) PID controller, fully pipelined.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: measured value
//   and setpoint, both signed fixed point with FRACTION_BITS fraction bits.
//   Output channel (o_out_valid / i_out_ready) returns one item per input:
//   the saturated integer drive value in -1000..1000.
//   Gains and mode are written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no item is in flight; a write takes effect at once.
// Pipeline: input register, four work stages, output register; o_out_valid
//   rises once the accepted item has passed through all of them.
// Throughput: one item per cycle while no stall holds the pipeline. The error
//   history and integral close their loop inside stage one, the held drive
//   inside the output stage, so consecutive items never wait for each other.
// Reset (synchronous, active low) clears gains, mode, error history, integral,
//   held drive and all valid flags; the block accepts an item right after.
// Stall: when the output register holds an item that is not taken, the whole
//   pipeline freezes and o_in_ready drops; nothing is lost or repeated.
module pid_controller_dual_mode_top #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  pid_dm_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [pid_dm_pkg::GAIN_W-1:0]          i_cfg_data,
    // input items
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pid_dm_pkg::DATA_W-1:0]   i_measured,
    input  logic signed [pid_dm_pkg::DATA_W-1:0]   i_setpoint,
    // result items
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pid_dm_pkg::DRIVE_W-1:0]  o_drive
);
    import pid_dm_pkg::*;

    // Derived widths
    localparam int F         = FRACTION_BITS;
    localparam int EW        = DATA_W + 1;              // error
    localparam int D1W       = EW + 1;                  // first difference
    localparam int D2W       = EW + 2;                  // second difference
    localparam int IW        = F + 11;                  // integral
    localparam int IOW       = (IW > EW) ? IW : EW;     // I multiplier operand
    localparam int IAW       = IOW + 1;                 // integral update
    localparam int PPW       = GAIN_W + D1W;
    localparam int PIW       = GAIN_W + IOW;
    localparam int PDW       = GAIN_W + D2W;
    localparam int MAXP      = (PIW > PDW) ? PIW : PDW;
    localparam int SUMW      = MAXP + 10;
    localparam int POS_SHIFT = 2 * F + 8;
    localparam int INC_SHIFT = 2 * F;
    localparam int DEAD_MAX_I = ((2 << F) - 1) / 10;

    localparam logic signed [EW-1:0]      DEAD_MAX    = EW'(DEAD_MAX_I);
    localparam logic signed [EW-1:0]      SMALL_LIM   = EW'(SMALL_SP << F);
    localparam logic signed [IAW-1:0]     POS_INT_LIM = IAW'(DRIVE_LIMIT << F);
    localparam logic signed [IAW-1:0]     INC_INT_LIM = IAW'(INC_INT_UNITS << F);
    localparam logic signed [SUMW-1:0]    POS_SUM_LIM = SUMW'(DRIVE_LIMIT) <<< POS_SHIFT;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX   = DRIVE_W'(DRIVE_LIMIT);
    localparam logic signed [SUMW:0]      ACC_MAX     = (SUMW + 1)'(DRIVE_LIMIT);

    // Configuration registers
    t_mode                     r_mode;
    logic signed [GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_POS;
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[0]);
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Global advance: every stage moves when the output register can take
    logic w_adv;
    logic r_in_v, r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;

    assign w_adv       = !r_out_v || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_in_v  <= i_in_valid;
            r_s1_v  <= r_in_v;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_out_v <= r_s4_v;
        end
    end

    // Input register
    logic signed [DATA_W-1:0] r_meas, r_sp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_meas <= i_measured;
            r_sp   <= i_setpoint;
        end
    end

    // Stage 1: error, deadband, differences, integral, operand select
    logic signed [EW-1:0]  r_err_last, r_err_prev;
    logic signed [IW-1:0]  r_integ;
    logic signed [EW-1:0]  n_e_raw, n_e, n_sp_ext;
    logic signed [D1W-1:0] n_d1;
    logic signed [D2W-1:0] n_d2;
    logic signed [IAW-1:0] n_isum, n_ilim, n_iclamp;
    logic signed [IW-1:0]  n_integ;
    logic                  n_small;

    always_comb begin
        n_e_raw  = EW'(r_sp) - EW'(r_meas);
        n_e      = (n_e_raw >= -DEAD_MAX && n_e_raw <= DEAD_MAX) ? '0 : n_e_raw;
        n_d1     = D1W'(n_e) - D1W'(r_err_last);
        n_d2     = D2W'(n_e) - (D2W'(r_err_last) <<< 1) + D2W'(r_err_prev);
        n_sp_ext = EW'(r_sp);
        n_small  = (n_sp_ext >= -SMALL_LIM) && (n_sp_ext <= SMALL_LIM);
        // integral update, limit depends on the control law
        n_isum   = IAW'(r_integ) + IAW'(n_e);
        n_ilim   = (r_mode == MODE_INC) ? INC_INT_LIM : POS_INT_LIM;
        priority if (n_isum > n_ilim) begin
            n_iclamp = n_ilim;
        end else if (n_isum < -n_ilim) begin
            n_iclamp = -n_ilim;
        end else begin
            n_iclamp = n_isum;
        end
        n_integ  = IW'(n_iclamp);
    end

    // history and integral close their loop here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_last <= '0;
            r_err_prev <= '0;
            r_integ    <= '0;
        end else if (w_adv && r_in_v) begin
            r_err_last <= n_e;
            r_integ    <= n_integ;
            if (r_mode == MODE_INC) begin
                r_err_prev <= r_err_last;
            end
        end
    end

    // multiplier operands per control law
    logic signed [D1W-1:0] r_op_p;
    logic signed [IOW-1:0] r_op_i;
    logic signed [D2W-1:0] r_op_d;
    logic                  r_s1_small;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_small <= n_small;
            if (r_mode == MODE_INC) begin
                r_op_p <= n_d1;
                r_op_i <= IOW'(n_e);
                r_op_d <= n_d2;
            end else begin
                r_op_p <= D1W'(n_e);
                r_op_i <= IOW'(n_integ);
                r_op_d <= D2W'(n_d1);
            end
        end
    end

    // Stage 2: three gain products
    logic signed [PPW-1:0] r_pp;
    logic signed [PIW-1:0] r_ip;
    logic signed [PDW-1:0] r_dp;
    logic                  r_s2_small;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pp       <= r_op_p * r_gain_p;
            r_ip       <= r_op_i * r_gain_i;
            r_dp       <= r_op_d * r_gain_d;
            r_s2_small <= r_s1_small;
        end
    end

    // Stage 3: align terms; positional I term scaled by 77/256 at small setpoints
    logic signed [SUMW-1:0] n_ip_ext, n_ti_pos;
    logic signed [SUMW-1:0] r_tp, r_ti, r_td;

    always_comb begin
        n_ip_ext = SUMW'(r_ip);
        n_ti_pos = r_s2_small
                 ? (n_ip_ext <<< 6) + (n_ip_ext <<< 3) + (n_ip_ext <<< 2) + n_ip_ext
                 : (n_ip_ext <<< 8);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_mode == MODE_INC) begin
                r_tp <= SUMW'(r_pp);
                r_ti <= n_ip_ext;
                r_td <= SUMW'(r_dp);
            end else begin
                r_tp <= SUMW'(r_pp) <<< 8;
                r_ti <= n_ti_pos;
                r_td <= SUMW'(r_dp) <<< 8;
            end
        end
    end

    // Stage 4: exact sum of the three terms
    logic signed [SUMW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum <= r_tp + r_ti + r_td;
        end
    end

    // Stage 5: truncate toward zero, saturate, held drive accumulate
    logic signed [DRIVE_W-1:0] r_held, r_drive;
    logic signed [SUMW-1:0]    n_pos_fl, n_inc_fl;
    logic                      n_pos_c, n_inc_c;
    logic signed [DRIVE_W-1:0] n_pos_drive, n_inc_drive;
    logic signed [SUMW:0]      n_acc;

    always_comb begin
        // positional: clamp then truncate
        n_pos_fl = r_sum >>> POS_SHIFT;
        n_pos_c  = r_sum[SUMW-1] && (|r_sum[POS_SHIFT-1:0]);
        priority if (r_sum > POS_SUM_LIM) begin
            n_pos_drive = DRIVE_MAX;
        end else if (r_sum < -POS_SUM_LIM) begin
            n_pos_drive = -DRIVE_MAX;
        end else begin
            n_pos_drive = n_pos_fl[DRIVE_W-1:0] + DRIVE_W'(n_pos_c);
        end
        // incremental: truncated increment added to held drive
        n_inc_fl = r_sum >>> INC_SHIFT;
        n_inc_c  = r_sum[SUMW-1] && (|r_sum[INC_SHIFT-1:0]);
        n_acc    = (SUMW + 1)'(r_held) + (SUMW + 1)'(n_inc_fl)
                 + (SUMW + 1)'($signed({1'b0, n_inc_c}));
        priority if (n_acc > ACC_MAX) begin
            n_inc_drive = DRIVE_MAX;
        end else if (n_acc < -ACC_MAX) begin
            n_inc_drive = -DRIVE_MAX;
        end else begin
            n_inc_drive = n_acc[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (w_adv && r_s4_v && r_mode == MODE_INC) begin
            r_held <= n_inc_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_drive <= (r_mode == MODE_INC) ? n_inc_drive : n_pos_drive;
        end
    end

    assign o_drive = r_drive;

    // Checks
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive <= DRIVE_MAX && o_drive >= -DRIVE_MAX))
        else $error("drive out of range");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held <= DRIVE_MAX && r_held >= -DRIVE_MAX))
        else $error("held drive out of range");

    a_deadband: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err_last != '0) |-> (r_err_last > DEAD_MAX || r_err_last < -DEAD_MAX))
        else $error("error inside deadband not zeroed");

    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IAW'(r_integ) <= POS_INT_LIM && IAW'(r_integ) >= -POS_INT_LIM))
        else $error("integral beyond limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_drive)
                                           && $stable(r_held)))
        else $error("output or held drive changed during stall");

endmodule

// ===== tb/sv/pid_dm_checker.sv =====
// Checker for the dual-mode PID controller: predicts each drive value and compares results.
module pid_dm_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  pid_dm_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [pid_dm_pkg::GAIN_W-1:0]          i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic signed [pid_dm_pkg::DATA_W-1:0]   i_measured,
    input  logic signed [pid_dm_pkg::DATA_W-1:0]   i_setpoint,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic signed [pid_dm_pkg::DRIVE_W-1:0]  i_drive,
    output int                                     o_mismatches,
    output int                                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pid_dm_pkg::*;

    // Fixed-point limits at the chosen fraction width
    localparam int     POS_SHIFT    = 2 * FRAC_BITS + 8;
    localparam int     INC_SHIFT    = 2 * FRAC_BITS;
    localparam longint DRIVE_LIM    = DRIVE_LIMIT;
    localparam longint POS_INT_LIM  = longint'(DRIVE_LIMIT) << FRAC_BITS;
    localparam longint INC_INT_LIM  = longint'(INC_INT_UNITS) << FRAC_BITS;
    localparam longint SMALL_SP_Q   = longint'(SMALL_SP) << FRAC_BITS;
    localparam longint DEADBAND_X10 = longint'(2) << FRAC_BITS;
    localparam longint I_GAIN_SMALL = 77;
    localparam longint I_GAIN_UNIT  = 256;

    // Controller state and settings as seen from the ports
    t_mode  ctl_mode;
    longint kp, ki, kd;
    longint err_prev, err_prev2, integ_acc, drive_held;

    logic signed [DRIVE_W-1:0] drive_expected_q [$];
    logic signed [DRIVE_W-1:0] want;
    int mismatch_count = 0;
    int results_seen   = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint saturate(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // One control step: updates the history and returns the drive value
    function automatic logic signed [DRIVE_W-1:0] compute_drive(input longint meas,
                                                                input longint sp);
        longint err, err_mag, sp_mag, i_gain_scale, acc, drive;
        err     = sp - meas;
        err_mag = (err < 0) ? -err : err;
        if (err_mag * 10 < DEADBAND_X10) err = 0;
        integ_acc += err;
        if (ctl_mode == MODE_POS) begin
            sp_mag       = (sp < 0) ? -sp : sp;
            i_gain_scale = (sp_mag <= SMALL_SP_Q) ? I_GAIN_SMALL : I_GAIN_UNIT;
            integ_acc    = saturate(integ_acc, POS_INT_LIM);
            acc = kp * err * 256 + i_gain_scale * ki * integ_acc
                + kd * (err - err_prev) * 256;
            acc   = saturate(acc, DRIVE_LIM << POS_SHIFT);
            drive = acc / (longint'(1) << POS_SHIFT);
            err_prev = err;
        end else begin
            integ_acc = saturate(integ_acc, INC_INT_LIM);
            acc = kp * (err - err_prev) + ki * err
                + kd * (err - 2 * err_prev + err_prev2);
            acc = acc / (longint'(1) << INC_SHIFT);
            err_prev2  = err_prev;
            err_prev   = err;
            drive_held = saturate(drive_held + acc, DRIVE_LIM);
            drive      = drive_held;
        end
        return drive[DRIVE_W-1:0];
    endfunction

    // Track register writes, score results, then predict new items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctl_mode   = MODE_POS;
            kp         = 0;
            ki         = 0;
            kd         = 0;
            err_prev   = 0;
            err_prev2  = 0;
            integ_acc  = 0;
            drive_held = 0;
            drive_expected_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:   ctl_mode = t_mode'(i_cfg_data[0]);
                    CFG_GAIN_P: kp = longint'($signed(i_cfg_data));
                    CFG_GAIN_I: ki = longint'($signed(i_cfg_data));
                    CFG_GAIN_D: kd = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            // result side first so a result never meets its own item
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (drive_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d drive=%0d with no item pending",
                                              results_seen, i_drive));
                end else begin
                    want = drive_expected_q.pop_front();
                    if (i_drive !== want)
                        report_mismatch($sformatf("result %0d drive=%0d, predicted %0d",
                                                  results_seen, i_drive, want));
                end
            end
            if (i_in_valid && i_in_ready)
                drive_expected_q.push_back(compute_drive(i_measured, i_setpoint));
            o_outstanding <= drive_expected_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_pid_controller_dual_mode_top.sv =====
// Testbench top for the dual-mode PID controller: stimulus, stalls and verdict.
module tb_pid_controller_dual_mode_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pid_dm_pkg::*;

    localparam int FRAC_BITS      = 8;
    localparam int PIPE_LATENCY   = 6;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 103;
    localparam int MAX_IN         = (1 << (DATA_W - 1)) - 1;
    localparam int MIN_IN         = -(1 << (DATA_W - 1));
    // largest error magnitude still inside the deadband
    localparam int DB_EDGE        = ((2 << FRAC_BITS) - 1) / 10;
    localparam int SMALL_SP_Q     = SMALL_SP << FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W - 1){1'b1}}};
    localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W - 1){1'b0}}};

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    t_cfg_idx                   i_cfg_index = CFG_MODE;
    logic [GAIN_W-1:0]          i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic signed [DATA_W-1:0]   i_measured  = '0;
    logic signed [DATA_W-1:0]   i_setpoint  = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [DRIVE_W-1:0]  o_drive;

    int   mismatches;
    int   outstanding;
    int   rx_style    = 1;
    logic rx_hold_req = 1'b0;

    pid_controller_dual_mode_top #(
        .FRACTION_BITS (FRAC_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_measured  (i_measured),
        .i_setpoint  (i_setpoint),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive)
    );

    pid_dm_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_measured    (i_measured),
        .i_setpoint    (i_setpoint),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_drive       (o_drive),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall pattern picked per phase, plus one long hold on request
    initial begin
        int beat;
        int hold_left;
        beat = 0;
        forever begin
            @(posedge i_clk);
            beat++;
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                hold_left = RX_HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
            end else begin
                case (rx_style)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_out_ready <= ((beat % 9) < 5);
                    default: i_out_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** pid_controller_dual_mode_top: FAILED **");
        $finish;
    end

    function automatic int rand_span(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain(input bit full);
        if (full) return GAIN_W'($urandom);
        return GAIN_W'(rand_span(3 << FRAC_BITS));
    endfunction

    // Random item: mostly realistic tracking errors, some edge cases and noise
    function automatic void make_item(output logic signed [DATA_W-1:0] meas,
                                      output logic signed [DATA_W-1:0] sp);
        int kind;
        int sp_v;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                meas = DATA_W'($urandom);
                sp   = DATA_W'($urandom);
            end
            1: begin
                sp_v = rand_span(4000);
                sp   = DATA_W'(sp_v);
                meas = DATA_W'(sp_v - rand_span(2 * DB_EDGE));
            end
            2: begin
                sp_v = SMALL_SP_Q + int'($urandom_range(0, 6)) - 3;
                if ($urandom_range(0, 1)) sp_v = -sp_v;
                sp   = DATA_W'(sp_v);
                meas = DATA_W'(sp_v - rand_span(8000));
            end
            default: begin
                sp_v = rand_span(300000);
                sp   = DATA_W'(sp_v);
                if ($urandom_range(0, 7) == 0)
                    meas = DATA_W'(sp_v - rand_span(300000));
                else
                    meas = DATA_W'(sp_v - rand_span(20000));
            end
        endcase
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] sp);
        i_in_valid <= 1'b1;
        i_measured <= meas;
        i_setpoint <= sp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [GAIN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Reprogram all registers once the pipeline has drained
    task automatic configure(input t_mode m, input logic [GAIN_W-1:0] gp,
                             input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd);
        logic [GAIN_W-1:0] mode_word;
        wait (outstanding == 0);
        repeat (PIPE_LATENCY) @(posedge i_clk);
        mode_word    = GAIN_W'($urandom);
        mode_word[0] = m;
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Deadband edges, small-setpoint edges and input extremes, back to back
    task automatic send_directed();
        logic signed [DATA_W-1:0] dir_meas [12];
        logic signed [DATA_W-1:0] dir_sp   [12];
        dir_sp   = '{0, DB_EDGE, -DB_EDGE, DB_EDGE + 1, -(DB_EDGE + 1),
                     SMALL_SP_Q, SMALL_SP_Q + 1, -SMALL_SP_Q, -(SMALL_SP_Q + 1),
                     MAX_IN, MIN_IN, MIN_IN};
        dir_meas = '{0, 0, 0, 0, 0,
                     SMALL_SP_Q - 5000, SMALL_SP_Q + 5001, -SMALL_SP_Q + 3000,
                     -SMALL_SP_Q - 3001, MIN_IN, MAX_IN, MIN_IN};
        foreach (dir_sp[k])
            send_item(dir_meas[k], dir_sp[k]);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random items in bursts, with optional gaps between bursts
    task automatic send_random(input int count, input bit gaps);
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] sp;
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            left -= burst;
            repeat (burst) begin
                make_item(meas, sp);
                send_item(meas, sp);
            end
            if (gaps && left > 0 && $urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Main sequence
    initial begin
        t_mode             ph_mode;
        logic [GAIN_W-1:0] gp, gi, gd;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(MODE_POS, GAIN_W'(4 << FRAC_BITS), GAIN_W'(1 << (FRAC_BITS - 1)),
                  GAIN_W'(2 << FRAC_BITS));
        send_directed();
        configure(MODE_INC, GAIN_MAX, GAIN_MIN, GAIN_MAX);
        send_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            ph_mode = t_mode'(p[0]);
            case (p)
                2: begin gp = GAIN_MAX; gi = GAIN_MAX; gd = GAIN_MAX; end
                3: begin gp = GAIN_MIN; gi = GAIN_MIN; gd = GAIN_MIN; end
                4: begin gp = '0; gi = rand_gain(1'b0); gd = '0; end
                5: begin gp = rand_gain(1'b1); gi = rand_gain(1'b1); gd = rand_gain(1'b1); end
                default: begin
                    gp = rand_gain(1'b0);
                    gi = rand_gain(1'b0);
                    gd = rand_gain(1'b0);
                end
            endcase
            configure(ph_mode, gp, gi, gd);
            rx_style = p % 4;
            if (p == 2) begin
                // receiver holds off while items keep coming: pipeline fills up
                rx_hold_req = 1'b1;
                send_random(PHASE_ITEMS, 1'b0);
            end else if (p == 6) begin
                send_random(PHASE_ITEMS / 2, 1'b1);
                wait (outstanding == 0);
                @(posedge i_clk);
                send_random(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b1);
            end else begin
                send_random(PHASE_ITEMS, p != 1);
            end
        end

        wait (outstanding == 0);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatches == 0)
            $display("** pid_controller_dual_mode_top: PASSED **");
        else
            $display("** pid_controller_dual_mode_top: FAILED **");
        $finish;
    end

endmodule
